>>> sv/tree_path_node_counter_assert.svh
// ----------------------------------------------------------------------------
// Tree path node counter assertion macros
// Shared concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TREE_PATH_NODE_COUNTER_ASSERT_SVH
`define TREE_PATH_NODE_COUNTER_ASSERT_SVH

// same-cycle implication
`define TPNC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpnc check failed");

// next-cycle implication
`define TPNC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpnc check failed");

`endif

>>> sv/tpnc_pkg.sv
// ----------------------------------------------------------------------------
// Tree path node counter package
// Request and response types, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package tpnc_pkg;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_PATH = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_BAD    = 2'd1;
	localparam logic [1:0] STS_FULL   = 2'd2;
	localparam logic [1:0] STS_NOPATH = 2'd3;

	localparam int COUNT_OUT_W = 32;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [10:0] node_a;
		logic [10:0] node_b;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic ready;
		logic done;
	} eng_flags_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_LRD1,
		S_LWR1,
		S_LRD2,
		S_LWR2,
		S_CRD,
		S_CLD,
		S_VCLR,
		S_POP,
		S_HEAD,
		S_HLD,
		S_SCAN,
		S_CHK,
		S_CHK2,
		S_TR,
		S_TR2,
		S_DONE
	} eng_state_t;

endpackage

>>> sv/tree_path_node_counter.sv
// ----------------------------------------------------------------------------
// Tree path node counter
// Edge store, depth-first path walk and saturating per-node counters.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------
//  request | req_valid, req_stall | req: cmd, node_a, node_b
//  result  | rsp_valid, rsp_stall | rsp: status, count
//
// After reset the head and counter memories are swept, every entry cleared.
// Add edge links both directions in (LRD1, LWR1, LRD2, LWR2); read loads the
// counter (CRD, CLD); equal path ends count that node once. Rejected requests
// and the unused command go straight to DONE. Path: clear visited marks, pop
// nodes and scan their edge entries, then count the path back along parents.
// One request at a time; the next is taken while a result waits in the
// output register, but the sequencer holds a finished result until it is free.
module tree_path_node_counter #(
	parameter int MAX_NODES   = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tpnc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tpnc_pkg::rsp_t rsp
);
	import tpnc_pkg::*;

	eng_flags_t flags;
	rsp_t       eng_rsp;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       out_free;
	logic       start;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign start     = req_valid && flags.ready;
	assign req_stall = !flags.ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tpnc_engine #(.MAX_NODES(MAX_NODES), .COUNT_WIDTH(COUNT_WIDTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.out_free(out_free), .flags(flags), .rsp(eng_rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (flags.done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flags.done) begin
			rsp_q <= eng_rsp;
		end
	end

endmodule

>>> sv/tpnc_ram.sv
// ----------------------------------------------------------------------------
// Tree path node counter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tpnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/tpnc_engine.sv
// ----------------------------------------------------------------------------
// Tree path node counter engine
// Sequencer over the edge, counter, walk and stack memories.
// ----------------------------------------------------------------------------
module tpnc_engine #(
	parameter int MAX_NODES   = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tpnc_pkg::req_t       req,
	input  logic                 out_free,
	output tpnc_pkg::eng_flags_t flags,
	output tpnc_pkg::rsp_t       rsp
);
	import tpnc_pkg::*;

	localparam int AW  = $clog2(MAX_NODES);
	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int EW  = $clog2(2 * MAX_NODES);
	localparam int PW  = $clog2(2 * MAX_NODES + 1);
	localparam int SPW = $clog2(MAX_NODES + 2);
	localparam int CW  = COUNT_WIDTH;

	eng_state_t state_q, state_nx;

	logic [PW-1:0]          fill_q;
	logic [AW-1:0]          idx_q;
	logic [NW-1:0]          a_q, b_q, x_q, sp_q;
	logic [SPW-1:0]         steps_q;
	logic [PW-1:0]          pops_q, p_q;
	logic [AW-1:0]          j_q, c_q;
	logic [1:0]             status_q;
	logic [COUNT_OUT_W-1:0] count_q;

	logic          hd_we;
	logic [AW-1:0] hd_wa, hd_ra;
	logic [PW-1:0] hd_wd, hd_rd;
	logic          nx_we;
	logic [EW-1:0] ed_wa, ed_ra;
	logic [PW-1:0] nx_wd, nx_rd;
	logic          tg_we;
	logic [AW-1:0] tg_wd, tg_rd;
	logic          cn_we;
	logic [AW-1:0] cn_wa, cn_ra;
	logic [CW-1:0] cn_wd, cn_rd;
	logic          pa_we;
	logic [AW-1:0] pa_wa, pa_ra;
	logic [NW-1:0] pa_wd, pa_rd;
	logic          vs_we;
	logic [AW-1:0] vs_wa, vs_ra;
	logic          vs_wd, vs_rd;
	logic          sk_we;
	logic [AW-1:0] sk_wa, sk_ra;
	logic [AW-1:0] sk_wd, sk_rd;

	logic          a_ok, b_ok, full, pop_end, sp_room, stop_tr, last_idx;
	logic [AW-1:0] a_idx, b_idx, x_idx;
	logic [PW-1:0] pcur;
	logic [CW-1:0] cnt_inc;
	logic [1:0]    sts_in;

	tpnc_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	tpnc_ram #(.WIDTH(PW), .DEPTH(2 * MAX_NODES)) u_next (
		.clk(clk), .we(nx_we), .waddr(ed_wa), .wdata(nx_wd), .raddr(ed_ra), .rdata(nx_rd));
	tpnc_ram #(.WIDTH(AW), .DEPTH(2 * MAX_NODES)) u_target (
		.clk(clk), .we(tg_we), .waddr(ed_wa), .wdata(tg_wd), .raddr(ed_ra), .rdata(tg_rd));
	tpnc_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_count (
		.clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(cn_ra), .rdata(cn_rd));
	tpnc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
		.clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd));
	tpnc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit (
		.clk(clk), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));
	tpnc_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));

	always_comb begin
		a_ok     = (req.node_a != '0) && (32'(req.node_a) <= 32'(MAX_NODES));
		b_ok     = (req.node_b != '0) && (32'(req.node_b) <= 32'(MAX_NODES));
		full     = (32'(fill_q) + 32'd2) > 32'(2 * MAX_NODES);
		a_idx    = AW'(a_q - NW'(1));
		b_idx    = AW'(b_q - NW'(1));
		x_idx    = AW'(x_q - NW'(1));
		pop_end  = (sp_q == '0) || (pops_q == PW'(2 * MAX_NODES));
		sp_room  = 32'(sp_q) < 32'(MAX_NODES);
		stop_tr  = (x_q == '0) || (32'(x_q) > 32'(MAX_NODES))
			|| (32'(steps_q) > 32'(MAX_NODES));
		last_idx = idx_q == AW'(MAX_NODES - 1);
		pcur     = (state_q == S_HLD) ? hd_rd : p_q;
		cnt_inc  = (cn_rd == '1) ? cn_rd : cn_rd + CW'(1);
		sts_in   = STS_OK;
		case (req.cmd)
			CMD_ADD: begin
				if (!a_ok || !b_ok) begin
					sts_in = STS_BAD;
				end else if (full) begin
					sts_in = STS_FULL;
				end
			end
			CMD_PATH: begin
				if (!a_ok || !b_ok) begin
					sts_in = STS_BAD;
				end
			end
			CMD_READ: begin
				if (!a_ok) begin
					sts_in = STS_BAD;
				end
			end
			default: sts_in = STS_OK;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLR: if (last_idx) state_nx = S_IDLE;
			S_IDLE: begin
				if (start) begin
					if (sts_in != STS_OK) begin
						state_nx = S_DONE;
					end else begin
						case (req.cmd)
							CMD_ADD:  state_nx = S_LRD1;
							CMD_PATH: state_nx = (req.node_a == req.node_b) ? S_TR : S_VCLR;
							CMD_READ: state_nx = S_CRD;
							default:  state_nx = S_DONE;
						endcase
					end
				end
			end
			S_LRD1: state_nx = S_LWR1;
			S_LWR1: state_nx = S_LRD2;
			S_LRD2: state_nx = S_LWR2;
			S_LWR2: state_nx = S_DONE;
			S_CRD:  state_nx = S_CLD;
			S_CLD:  state_nx = S_DONE;
			S_VCLR: if (last_idx) state_nx = S_POP;
			S_POP:  state_nx = pop_end ? S_DONE : S_HEAD;
			S_HEAD: state_nx = S_HLD;
			S_HLD, S_SCAN: state_nx = (pcur == '0) ? S_POP : S_CHK;
			S_CHK:  state_nx = S_CHK2;
			S_CHK2: state_nx = (!vs_rd && c_q == b_idx) ? S_TR : S_SCAN;
			S_TR:   state_nx = stop_tr ? S_DONE : S_TR2;
			S_TR2:  state_nx = S_TR;
			S_DONE: if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
		nx_we = 1'b0; tg_we = 1'b0; ed_wa = EW'(fill_q); ed_ra = '0;
		nx_wd = hd_rd; tg_wd = b_idx;
		cn_we = 1'b0; cn_wa = x_idx; cn_wd = cnt_inc; cn_ra = '0;
		pa_we = 1'b0; pa_wa = c_q; pa_wd = NW'(j_q) + NW'(1); pa_ra = '0;
		vs_we = 1'b0; vs_wa = idx_q; vs_wd = 1'b0; vs_ra = '0;
		sk_we = 1'b0; sk_wa = AW'(sp_q); sk_wd = c_q; sk_ra = '0;
		unique case (state_q)
			S_CLR: begin
				hd_we = 1'b1; hd_wa = idx_q;
				cn_we = 1'b1; cn_wa = idx_q; cn_wd = '0;
			end
			S_LRD1: hd_ra = a_idx;
			S_LWR1: begin
				nx_we = 1'b1; tg_we = 1'b1;
				hd_we = 1'b1; hd_wa = a_idx; hd_wd = fill_q + PW'(1);
			end
			S_LRD2: hd_ra = b_idx;
			S_LWR2: begin
				nx_we = 1'b1; tg_we = 1'b1; tg_wd = a_idx;
				hd_we = 1'b1; hd_wa = b_idx; hd_wd = fill_q + PW'(1);
			end
			S_CRD: cn_ra = a_idx;
			S_VCLR: begin
				vs_we = 1'b1;
				pa_we = 1'b1; pa_wa = a_idx; pa_wd = '0;
				sk_we = 1'b1; sk_wa = '0; sk_wd = a_idx;
			end
			S_POP: sk_ra = AW'(sp_q - NW'(1));
			S_HEAD: begin
				hd_ra = sk_rd;
				vs_we = 1'b1; vs_wa = sk_rd; vs_wd = 1'b1;
			end
			S_HLD, S_SCAN: ed_ra = EW'(pcur - PW'(1));
			S_CHK: vs_ra = tg_rd;
			S_CHK2: begin
				if (!vs_rd) begin
					pa_we = 1'b1;
					sk_we = (c_q != b_idx) && sp_room;
				end
			end
			S_TR: begin
				cn_ra = x_idx;
				pa_ra = x_idx;
			end
			S_TR2: cn_we = 1'b1;
			default: hd_ra = '0;
		endcase
	end

	always_comb begin
		flags.ready = state_q == S_IDLE;
		flags.done  = (state_q == S_DONE) && out_free;
		rsp.status  = status_q;
		rsp.count   = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLR || state_q == S_VCLR) begin
				idx_q <= idx_q + AW'(1);
			end else if (state_q == S_IDLE) begin
				idx_q <= '0;
			end
			if (state_q == S_LWR1 || state_q == S_LWR2) begin
				fill_q <= fill_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a_q      <= NW'(req.node_a);
				b_q      <= NW'(req.node_b);
				x_q      <= NW'(req.node_a);
				steps_q  <= SPW'(MAX_NODES);
				sp_q     <= NW'(1);
				pops_q   <= '0;
				status_q <= sts_in;
				count_q  <= '0;
			end
			S_CLD: count_q <= COUNT_OUT_W'(cn_rd);
			S_POP: begin
				if (pop_end) begin
					status_q <= STS_NOPATH;
				end else begin
					sp_q   <= sp_q - NW'(1);
					pops_q <= pops_q + PW'(1);
				end
			end
			S_HEAD: j_q <= sk_rd;
			S_HLD:  p_q <= hd_rd;
			S_CHK: begin
				c_q <= tg_rd;
				p_q <= nx_rd;
			end
			S_CHK2: begin
				if (!vs_rd) begin
					if (c_q == b_idx) begin
						x_q     <= b_q;
						steps_q <= '0;
					end else if (sp_room) begin
						sp_q <= sp_q + NW'(1);
					end
				end
			end
			S_TR2: begin
				x_q     <= pa_rd;
				steps_q <= steps_q + SPW'(1);
			end
			default: j_q <= j_q;
		endcase
	end

`include "tree_path_node_counter_assert.svh"

	`TPNC_ASSERT_NEXT(a_start_leaves_idle, flags.ready && start, state_q != S_IDLE)
	`TPNC_ASSERT_NEXT(a_done_to_idle, flags.done, state_q == S_IDLE)
	`TPNC_ASSERT_NEXT(a_fill_step, state_q == S_LWR1 || state_q == S_LWR2, fill_q == $past(fill_q) + PW'(1))

endmodule
